FILE: rtl/sfr_pkg.sv
package sfr_pkg;

  // framing bytes
  localparam logic [7:0] SYNC_A    = 8'hED;
  localparam logic [7:0] SYNC_B    = 8'hF0;
  localparam logic [7:0] BROADCAST = 8'hFF;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd1;

  // configuration reset values
  localparam logic [7:0]  OWN_ADDRESS_RESET  = 8'h00;
  localparam logic [15:0] LENGTH_LIMIT_RESET = 16'd256;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
  localparam logic [2:0] KIND_FRAME_OK  = 3'd1;
  localparam logic [2:0] KIND_CHECK_ERR = 3'd2;
  localparam logic [2:0] KIND_LEN_ERR   = 3'd3;
  localparam logic [2:0] KIND_ADDR_ERR  = 3'd4;

  // parser phase
  typedef enum logic [3:0] {
    PH_SYNC1 = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_SYNC3 = 4'd2,
    PH_ADDR  = 4'd3,
    PH_CMD   = 4'd4,
    PH_LENH  = 4'd5,
    PH_LENL  = 4'd6,
    PH_DATA  = 4'd7,
    PH_CHECK = 4'd8
  } phase_t;

  // one result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  command;
    logic [15:0] payload_length;
  } result_t;

endpackage

FILE: rtl/serial_frame_receiver.sv
// Serial frame receiver: takes one received byte per word on the input
// channel (in_valid / in_ready / rx_byte), finds frames that start with
// ED ED F0, checks address, length and XOR checksum, and emits payload
// bytes and one status word per frame on the output channel (out_valid /
// out_ready / kind, data_byte, command, payload_length).
// Configuration is a separate write channel (cfg_valid / cfg_ready /
// cfg_index / cfg_data): index 0 own address, index 1 length limit;
// cfg_ready is always high and writes should be made while idle.
// Throughput is one input word per cycle while in_ready is high; the
// parser decides each byte in a single pass of logic from its phase
// register to the result queue, where the result is registered.
// Results wait in a two-word queue, so input keeps flowing while a word
// waits; in_ready drops only when both queue words are held, i.e. when
// the downstream side stalls. No result is lost or repeated.
// Synchronous reset (rst) empties the queue, returns the parser to the
// sync hunt and sets own address 0 and length limit 256.
module serial_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  command,
  output logic [15:0] payload_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic             byte_fire;
  logic             res_valid;
  sfr_pkg::result_t res;
  sfr_pkg::result_t head;
  logic             not_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = not_full;
  assign byte_fire = in_valid && not_full;

  // byte parser with frame state
  sfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_fire (byte_fire),
    .rx_byte   (rx_byte),
    .cfg_fire  (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue towards the output channel
  sfr_result_q u_result_q (
    .clk        (clk),
    .rst        (rst),
    .push       (byte_fire && res_valid),
    .push_res   (res),
    .not_full   (not_full),
    .head_valid (out_valid),
    .pop        (out_valid && out_ready),
    .head       (head)
  );

  assign kind           = head.kind;
  assign data_byte      = head.data_byte;
  assign command        = head.command;
  assign payload_length = head.payload_length;

endmodule

FILE: rtl/sfr_parser.sv
module sfr_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_fire,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_fire,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output logic             res_valid,
  output sfr_pkg::result_t res
);

  sfr_pkg::phase_t phase, phase_next;
  logic [7:0]  own_address;
  logic [15:0] length_limit;
  logic [7:0]  frame_command, frame_command_next;
  logic [7:0]  len_high, len_high_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] len_full;
  logic [15:0] seen_inc;

  assign len_full = {len_high, rx_byte};
  assign seen_inc = bytes_seen + 16'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= sfr_pkg::OWN_ADDRESS_RESET;
      length_limit <= sfr_pkg::LENGTH_LIMIT_RESET;
    end else if (cfg_fire) begin
      if (cfg_index == sfr_pkg::REG_OWN_ADDRESS) begin
        own_address <= cfg_data[7:0];
      end else if (cfg_index == sfr_pkg::REG_LENGTH_LIMIT) begin
        length_limit <= cfg_data;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfr_pkg::PH_SYNC1;
      frame_command <= '0;
      len_high      <= '0;
      frame_length  <= '0;
      bytes_seen    <= '0;
      running_xor   <= '0;
    end else if (byte_fire) begin
      phase         <= phase_next;
      frame_command <= frame_command_next;
      len_high      <= len_high_next;
      frame_length  <= frame_length_next;
      bytes_seen    <= bytes_seen_next;
      running_xor   <= running_xor_next;
    end
  end

  // next state and result for the incoming byte
  always_comb begin
    phase_next         = phase;
    frame_command_next = frame_command;
    len_high_next      = len_high;
    frame_length_next  = frame_length;
    bytes_seen_next    = bytes_seen;
    running_xor_next   = running_xor;
    res_valid          = 1'b0;
    res.kind           = sfr_pkg::KIND_PAYLOAD;
    res.data_byte      = '0;
    res.command        = frame_command;
    res.payload_length = frame_length;
    unique case (phase)
      sfr_pkg::PH_SYNC2: begin
        if (rx_byte == sfr_pkg::SYNC_A) begin
          phase_next = sfr_pkg::PH_SYNC3;
        end else begin
          phase_next = sfr_pkg::PH_SYNC1;
        end
      end
      sfr_pkg::PH_SYNC3: begin
        if (rx_byte == sfr_pkg::SYNC_B) begin
          phase_next = sfr_pkg::PH_ADDR;
        end else if (rx_byte == sfr_pkg::SYNC_A) begin
          phase_next = sfr_pkg::PH_SYNC2;
        end else begin
          phase_next = sfr_pkg::PH_SYNC1;
        end
      end
      sfr_pkg::PH_ADDR: begin
        if (rx_byte != sfr_pkg::BROADCAST && rx_byte != own_address) begin
          phase_next         = sfr_pkg::PH_SYNC1;
          res_valid          = 1'b1;
          res.kind           = sfr_pkg::KIND_ADDR_ERR;
          res.command        = '0;
          res.payload_length = '0;
        end else begin
          running_xor_next = rx_byte;
          phase_next       = sfr_pkg::PH_CMD;
        end
      end
      sfr_pkg::PH_CMD: begin
        frame_command_next = rx_byte;
        running_xor_next   = running_xor ^ rx_byte;
        phase_next         = sfr_pkg::PH_LENH;
      end
      sfr_pkg::PH_LENH: begin
        len_high_next    = rx_byte;
        running_xor_next = running_xor ^ rx_byte;
        phase_next       = sfr_pkg::PH_LENL;
      end
      sfr_pkg::PH_LENL: begin
        frame_length_next = len_full;
        running_xor_next  = running_xor ^ rx_byte;
        bytes_seen_next   = '0;
        if (len_full >= length_limit) begin
          phase_next         = sfr_pkg::PH_SYNC1;
          res_valid          = 1'b1;
          res.kind           = sfr_pkg::KIND_LEN_ERR;
          res.payload_length = len_full;
        end else if (len_full == 16'd0) begin
          phase_next = sfr_pkg::PH_CHECK;
        end else begin
          phase_next = sfr_pkg::PH_DATA;
        end
      end
      sfr_pkg::PH_DATA: begin
        running_xor_next = running_xor ^ rx_byte;
        bytes_seen_next  = seen_inc;
        if (seen_inc >= frame_length) begin
          phase_next = sfr_pkg::PH_CHECK;
        end
        res_valid     = 1'b1;
        res.kind      = sfr_pkg::KIND_PAYLOAD;
        res.data_byte = rx_byte;
      end
      sfr_pkg::PH_CHECK: begin
        phase_next = sfr_pkg::PH_SYNC1;
        res_valid  = 1'b1;
        res.kind   = (rx_byte == running_xor) ? sfr_pkg::KIND_FRAME_OK
                                              : sfr_pkg::KIND_CHECK_ERR;
      end
      default: begin
        // first sync byte hunt, also for unused codes
        if (rx_byte == sfr_pkg::SYNC_A) begin
          phase_next = sfr_pkg::PH_SYNC2;
        end else begin
          phase_next = sfr_pkg::PH_SYNC1;
        end
      end
    endcase
  end

endmodule

FILE: rtl/sfr_result_q.sv
module sfr_result_q (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfr_pkg::result_t push_res,
  output logic             not_full,
  output logic             head_valid,
  input  logic             pop,
  output sfr_pkg::result_t head
);

  logic [1:0] count, count_next;
  sfr_pkg::result_t slot0, slot0_next;
  sfr_pkg::result_t slot1, slot1_next;

  assign not_full   = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot0;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  // two-word queue update
  always_comb begin
    count_next = count;
    slot0_next = slot0;
    slot1_next = slot1;
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot0_next = push_res;
        end else begin
          slot1_next = push_res;
        end
        count_next = count + 2'd1;
      end
      2'b01: begin
        slot0_next = slot1;
        count_next = count - 2'd1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0_next = push_res;
        end else begin
          slot0_next = slot1;
          slot1_next = push_res;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

endmodule

FILE: dv/serial_frame_receiver_checker.sv
`timescale 1ns / 1ps

// watches the byte, result and register channels, tracks the frame parser
// and compares every result word with the oldest predicted one
module serial_frame_receiver_checker
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  command,
  input  logic [15:0] payload_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          results_outstanding
);

  // register copies
  logic [7:0]  own_addr_reg;
  logic [15:0] len_limit_reg;

  // parser copy
  phase_t      parse_phase;
  logic [7:0]  hdr_command;
  logic [15:0] hdr_length;
  logic [15:0] payload_count;
  logic [7:0]  frame_xor;

  // predicted result words, oldest first
  result_t     frame_results_q[$];

  function automatic phase_t hunt_phase(input logic [7:0] b);
    return (b == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
  endfunction

  task automatic push_result(input logic [2:0] k, input logic [7:0] d,
                             input logic [7:0] c, input logic [15:0] l);
    result_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.command        = c;
    r.payload_length = l;
    frame_results_q.push_back(r);
  endtask

  // advance the parser copy by one received byte
  task automatic deframe_byte(input logic [7:0] b);
    case (parse_phase)
      PH_SYNC2: begin
        parse_phase = (b == SYNC_A) ? PH_SYNC3 : hunt_phase(b);
      end
      PH_SYNC3: begin
        parse_phase = (b == SYNC_B) ? PH_ADDR : hunt_phase(b);
      end
      PH_ADDR: begin
        if (b != BROADCAST && b != own_addr_reg) begin
          parse_phase = PH_SYNC1;
          push_result(KIND_ADDR_ERR, 8'h00, 8'h00, 16'h0000);
        end else begin
          frame_xor   = b;
          parse_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        hdr_command = b;
        frame_xor   = frame_xor ^ b;
        parse_phase = PH_LENH;
      end
      PH_LENH: begin
        hdr_length  = {b, 8'h00};
        frame_xor   = frame_xor ^ b;
        parse_phase = PH_LENL;
      end
      PH_LENL: begin
        hdr_length[7:0] = b;
        frame_xor       = frame_xor ^ b;
        payload_count   = 16'h0000;
        if (hdr_length >= len_limit_reg) begin
          parse_phase = PH_SYNC1;
          push_result(KIND_LEN_ERR, 8'h00, hdr_command, hdr_length);
        end else begin
          parse_phase = (hdr_length == 16'h0000) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        frame_xor     = frame_xor ^ b;
        payload_count = payload_count + 16'd1;
        if (payload_count >= hdr_length) parse_phase = PH_CHECK;
        push_result(KIND_PAYLOAD, b, hdr_command, hdr_length);
      end
      PH_CHECK: begin
        parse_phase = PH_SYNC1;
        push_result((b == frame_xor) ? KIND_FRAME_OK : KIND_CHECK_ERR,
                    8'h00, hdr_command, hdr_length);
      end
      default: begin
        parse_phase = hunt_phase(b);
      end
    endcase
  endtask

  task automatic compare_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // one result word leaving the block
  task automatic check_word();
    result_t want;
    if (frame_results_q.size() == 0) begin
      $display("%0t ns: result word expected none got kind 0x%0h data 0x%0h",
               $time, kind, data_byte);
      mismatch_count++;
    end else begin
      want = frame_results_q.pop_front();
      compare_field("kind", 16'(want.kind), 16'(kind));
      compare_field("data_byte", 16'(want.data_byte), 16'(data_byte));
      compare_field("command", 16'(want.command), 16'(command));
      compare_field("payload_length", want.payload_length, payload_length);
    end
  endtask

  // sample all channels on the rising edge; results leave before bytes enter
  always @(posedge clk) begin
    if (rst) begin
      own_addr_reg   = OWN_ADDRESS_RESET;
      len_limit_reg  = LENGTH_LIMIT_RESET;
      parse_phase    = PH_SYNC1;
      hdr_command    = 8'h00;
      hdr_length     = 16'h0000;
      payload_count  = 16'h0000;
      frame_xor      = 8'h00;
      mismatch_count = 0;
      frame_results_q.delete();
    end else begin
      if (out_valid && out_ready) check_word();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OWN_ADDRESS:  own_addr_reg = cfg_data[7:0];
          REG_LENGTH_LIMIT: len_limit_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) deframe_byte(rx_byte);
    end
    results_outstanding <= frame_results_q.size();
  end

endmodule

FILE: dv/serial_frame_receiver_tb.sv
`timescale 1ns / 1ps

module serial_frame_receiver_tb;
  import sfr_pkg::*;

  localparam int         LATENCY_CYCLES   = 4;
  localparam int         LONG_HOLD_CYCLES = 60;
  localparam int         PHASE_BYTES      = 35;
  localparam logic [1:0] REG_UNUSED       = 2'd2;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} stall_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  command;
  logic [15:0] payload_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int          mismatch_count;
  int          results_outstanding;
  int          hold_req;
  int          burst_left;
  int          bytes_sent;
  logic [7:0]  tb_own_addr;
  logic [15:0] tb_len_limit;

  serial_frame_receiver u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .command        (command),
    .payload_length (payload_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  serial_frame_receiver_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .rx_byte             (rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .kind                (kind),
    .data_byte           (data_byte),
    .command             (command),
    .payload_length      (payload_length),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: stall modes of random length, plus the long hold on request
  initial begin : result_stall
    stall_mode_t mode;
    int          mode_left;
    int          served;
    int          tick;
    mode      = READY_ALWAYS;
    mode_left = 0;
    served    = 0;
    tick      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != served) begin
        served = hold_req;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      tick++;
      case (mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= (tick % 3 != 0);
      endcase
    end
  end

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int          gap;
    int unsigned pick;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pick = $urandom_range(0, 99);
      if (pick < 35) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 4);
      else gap = $urandom_range(8, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_word(input logic [7:0] b);
    pace_sender();
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // stop sending until every predicted word has left, then let the block settle
  task automatic idle_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no lowering
  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OWN_ADDRESS:  tb_own_addr = value[7:0];
      REG_LENGTH_LIMIT: tb_len_limit = value;
      default: ;
    endcase
  endtask

  // full frame; stops where the block is known to give up on it
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [15:0] len, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] pb;
    send_word(SYNC_A);
    send_word(SYNC_A);
    send_word(SYNC_B);
    send_word(addr);
    if (addr != BROADCAST && addr != tb_own_addr) return;
    send_word(cmd);
    send_word(len[15:8]);
    send_word(len[7:0]);
    if (len >= tb_len_limit) return;
    sum = addr ^ cmd ^ len[15:8] ^ len[7:0];
    for (int i = 0; i < int'(len); i++) begin
      pb  = 8'($urandom_range(0, 255));
      sum = sum ^ pb;
      send_word(pb);
    end
    pb = 8'($urandom_range(1, 255));
    send_word(bad_sum ? (sum ^ pb) : sum);
  endtask

  task automatic random_frame();
    logic [7:0]  addr;
    logic [15:0] len;
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(0, 99);
    if (pick < 45) addr = tb_own_addr;
    else if (pick < 75) addr = BROADCAST;
    else addr = 8'($urandom_range(0, 255));
    top  = (tb_len_limit > 16'd1) ? tb_len_limit - 1 : 0;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = 16'($urandom_range(tb_len_limit, 16'hFFFF));
    else if (pick < 15) len = 16'($urandom_range(0, (top < 40) ? top : 40));
    else len = 16'($urandom_range(0, (top < 6) ? top : 6));
    send_frame(addr, 8'($urandom_range(0, 255)), len, $urandom_range(0, 99) < 15);
  endtask

  // stray bytes, often sync bytes or a sync sequence cut short
  task automatic send_noise();
    int          n;
    int unsigned pick;
    logic [7:0]  b;
    if ($urandom_range(0, 1) == 1) begin
      send_word(SYNC_A);
      send_word(SYNC_A);
    end
    n = $urandom_range(1, 4);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) b = SYNC_A;
      else if (pick < 45) b = SYNC_B;
      else b = 8'($urandom_range(0, 255));
      send_word(b);
    end
  endtask

  task automatic run_random_phase(input int n);
    int          start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_frame();
      end else if (pick < 92) begin
        send_noise();
      end else if (pick < 96) begin
        hold_req <= hold_req + 1;
        random_frame();
      end else begin
        idle_until_drained();
      end
    end
  endtask

  // stimulus
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    cfg_valid    = 1'b0;
    cfg_index    = REG_OWN_ADDRESS;
    cfg_data     = 16'h0000;
    hold_req     = 0;
    burst_left   = 0;
    bytes_sent   = 0;
    tb_own_addr  = OWN_ADDRESS_RESET;
    tb_len_limit = LENGTH_LIMIT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed frames at the reset settings
    send_frame(8'h00, 8'h5A, 16'd0, 1'b0);
    send_word(SYNC_A);
    send_word(SYNC_A);
    send_frame(BROADCAST, 8'hA5, 16'd2, 1'b0);
    send_frame(8'h37, 8'h11, 16'd1, 1'b0);
    send_frame(BROADCAST, 8'hFF, 16'd1, 1'b1);
    send_frame(8'h00, 8'h80, 16'hFFFF, 1'b0);
    send_frame(8'h00, 8'h00, 16'd256, 1'b0);

    // long hold while the sender keeps going, then random frames
    hold_req <= hold_req + 1;
    send_frame(tb_own_addr, 8'h3C, 16'd8, 1'b0);
    run_random_phase(PHASE_BYTES);
    idle_until_drained();

    // address equal to broadcast, length limit 1
    write_cfg(REG_OWN_ADDRESS, {8'($urandom_range(0, 255)), BROADCAST});
    write_cfg(REG_LENGTH_LIMIT, 16'd1);
    cfg_valid <= 1'b0;
    run_random_phase(PHASE_BYTES);
    idle_until_drained();

    // largest limit, random address, write to an unused index
    write_cfg(REG_LENGTH_LIMIT, 16'hFFFF);
    write_cfg(REG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
    write_cfg(REG_OWN_ADDRESS, 16'($urandom_range(0, 16'hFFFF)));
    cfg_valid <= 1'b0;
    send_frame(tb_own_addr, 8'h96, 16'd257, 1'b0);
    run_random_phase(PHASE_BYTES);
    idle_until_drained();

    // address zero, small limit
    write_cfg(REG_OWN_ADDRESS, 16'h0000);
    write_cfg(REG_LENGTH_LIMIT, 16'd7);
    cfg_valid <= 1'b0;
    run_random_phase(PHASE_BYTES);
    idle_until_drained();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
